// ===== hw/rtl/aip_pkg.sv =====
// aip_pkg: constants, codes and helper functions for the ASCII integer parser.
// No dependencies; used by ascii_integer_parser through scoped names.
package aip_pkg;

    localparam int unsigned MAX_CHARS = 4096;
    localparam int unsigned POS_W     = 13;
    localparam int unsigned VAL_W     = 64;
    localparam int unsigned ST_W      = 2;
    localparam int unsigned OUT_W     = 80;   // 64 + 2 + 13 = 79, padded to bytes

    // parse phases
    localparam logic [2:0] PH_WS     = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_AUTO0  = 3'd2;
    localparam logic [2:0] PH_HEX0   = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_DRAIN  = 3'd5;

    // base_code register values
    localparam logic [2:0] BC_AUTO = 3'd0;
    localparam logic [2:0] BC_BIN  = 3'd1;
    localparam logic [2:0] BC_OCT  = 3'd2;
    localparam logic [2:0] BC_DEC  = 3'd3;
    localparam logic [2:0] BC_HEX  = 3'd4;

    // active base, internal encoding
    localparam logic [1:0] AB_2  = 2'd0;
    localparam logic [1:0] AB_8  = 2'd1;
    localparam logic [1:0] AB_10 = 2'd2;
    localparam logic [1:0] AB_16 = 2'd3;

    // register indexes on the config port
    localparam logic [1:0] REG_BASE_CODE     = 2'd0;
    localparam logic [1:0] REG_WANT_UNSIGNED = 2'd1;
    localparam logic [1:0] REG_WIDTH_CODE    = 2'd2;

    // width_code values
    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;
    localparam logic [1:0] WC_32 = 2'd2;
    localparam logic [1:0] WC_64 = 2'd3;

    // result status
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_FMT = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    // characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    localparam logic [63:0] UMAX_W8  = 64'h0000_0000_0000_00FF;
    localparam logic [63:0] UMAX_W16 = 64'h0000_0000_0000_FFFF;
    localparam logic [63:0] UMAX_W32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] UMAX_W64 = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [63:0] LIM10_W8  = UMAX_W8 / 10;
    localparam logic [63:0] LIM10_W16 = UMAX_W16 / 10;
    localparam logic [63:0] LIM10_W32 = UMAX_W32 / 10;
    localparam logic [63:0] LIM10_W64 = UMAX_W64 / 10;
    localparam logic [3:0]  REM10     = 4'd5;   // same remainder at every width

    typedef logic [63:0] t_value;

    function automatic t_value umax_of(input logic [1:0] wc);
        t_value u;
        case (wc)
            WC_8:    u = UMAX_W8;
            WC_16:   u = UMAX_W16;
            WC_32:   u = UMAX_W32;
            default: u = UMAX_W64;
        endcase
        return u;
    endfunction

    function automatic t_value lim10_of(input logic [1:0] wc);
        t_value l;
        case (wc)
            WC_8:    l = LIM10_W8;
            WC_16:   l = LIM10_W16;
            WC_32:   l = LIM10_W32;
            default: l = LIM10_W64;
        endcase
        return l;
    endfunction

    // {valid, value}
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] r;
        if (c inside {[CH_0:CH_9]}) begin
            r = {1'b1, 4'(c - CH_0)};
        end else if (c inside {[CH_UA:CH_UF]}) begin
            r = {1'b1, 4'(c - CH_UA + 8'd10)};
        end else if (c inside {[CH_LA:CH_LF]}) begin
            r = {1'b1, 4'(c - CH_LA + 8'd10)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ascii_integer_parser.sv =====
// ascii_integer_parser: streaming strtol-style string to integer converter.
// Depends on aip_pkg (codes, limits, digit decode).
//
//  channel   dir  handshake                     payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: ch[7:0]; tlast: last
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: value, status, stop_offset
//  cfg       in   i_cfg_we                      i_cfg_index, i_cfg_data
//
// One character per cycle sustained while the output is not back-pressured. An item
// passes an input register, the parse step (state update, digit shift-add and range
// compare), a pending-result register and the saturate/negate step into the output
// register. Each stage holds only while the one after it is full and cannot move on, so a
// result waiting in the pending register stalls the input too. Synchronous reset clears the
// valid flags and parse state; config regs return to decimal, signed, 32-bit.
module ascii_integer_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // [63:0] value, [65:64] status,
                                          // [78:66] stop_offset, [79] zero
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_data
);

    // config
    logic [2:0] r_base_code;
    logic       r_want_unsigned;
    logic [1:0] r_width_code;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_last;

    // parse state
    logic [2:0]  r_phase, n_phase;
    logic [63:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic        r_ovf, n_ovf;
    logic [1:0]  r_base, n_base;
    logic [12:0] r_pos, pos_inc;

    // pending result
    logic        r_pend_valid;
    logic        r_pend_err;
    logic [63:0] r_pend_acc;
    logic        r_pend_neg;
    logic        r_pend_ovf;
    logic        r_pend_uns;
    logic [1:0]  r_pend_wc;
    logic [12:0] r_pend_off;

    // output register
    logic        r_out_valid;
    logic [79:0] r_out_data;

    logic out_ready, proc_ready, proc_fire, in_fire, pend_move;

    assign out_ready       = !r_out_valid || i_m_axis_tready;
    assign proc_ready      = !r_pend_valid || out_ready;
    assign proc_fire       = r_in_valid && proc_ready;
    assign o_s_axis_tready = !r_in_valid || proc_ready;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign pend_move       = r_pend_valid && out_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ---------------- parse step ----------------
    logic [1:0]  td_base, code_base;
    logic [4:0]  dig;
    logic        d_ok, can_acc;
    logic [63:0] umax, lim, acc_mul, acc_next;
    logic [3:0]  rem;
    logic        is_ws, is_sign, is_x, is_zero;
    logic        fc_go, td_go;
    logic        res_valid, res_err;
    logic [12:0] res_off;

    assign pos_inc = (r_pos < 13'(aip_pkg::MAX_CHARS)) ? r_pos + 13'd1 : r_pos;
    assign is_ws   = (r_in_ch == aip_pkg::CH_SPACE) ||
                     (r_in_ch inside {[aip_pkg::CH_TAB:aip_pkg::CH_CR]});
    assign is_sign = (r_in_ch == aip_pkg::CH_MINUS) || (r_in_ch == aip_pkg::CH_PLUS);
    assign is_x    = (r_in_ch == aip_pkg::CH_LX) || (r_in_ch == aip_pkg::CH_UX);
    assign is_zero = (r_in_ch == aip_pkg::CH_0);

    always_comb begin
        case (r_base_code)
            aip_pkg::BC_BIN: code_base = aip_pkg::AB_2;
            aip_pkg::BC_OCT: code_base = aip_pkg::AB_8;
            aip_pkg::BC_HEX: code_base = aip_pkg::AB_16;
            default:         code_base = aip_pkg::AB_10;
        endcase
    end

    // first character resolves the base this cycle; later phases use the latched one
    assign td_base = (r_phase == aip_pkg::PH_WS || r_phase == aip_pkg::PH_SIGNED)
                     ? code_base : r_base;

    assign dig  = aip_pkg::digit_of(r_in_ch);
    assign umax = aip_pkg::umax_of(r_width_code);

    always_comb begin
        case (td_base)
            aip_pkg::AB_2: begin
                d_ok    = (dig[3:0] < 4'd2);
                lim     = umax >> 1;
                rem     = 4'd1;
                acc_mul = {r_acc[62:0], 1'b0};
            end
            aip_pkg::AB_8: begin
                d_ok    = (dig[3:0] < 4'd8);
                lim     = umax >> 3;
                rem     = 4'd7;
                acc_mul = {r_acc[60:0], 3'b000};
            end
            aip_pkg::AB_16: begin
                d_ok    = 1'b1;
                lim     = umax >> 4;
                rem     = 4'd15;
                acc_mul = {r_acc[59:0], 4'b0000};
            end
            default: begin
                d_ok    = (dig[3:0] < 4'd10);
                lim     = aip_pkg::lim10_of(r_width_code);
                rem     = aip_pkg::REM10;
                acc_mul = {r_acc[60:0], 3'b000} + {r_acc[62:0], 1'b0};
            end
        endcase
    end

    assign acc_next = acc_mul + {60'd0, dig[3:0]};
    assign can_acc  = (r_acc < lim) || ((r_acc == lim) && (dig[3:0] <= rem));

    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_ovf     = r_ovf;
        n_base    = r_base;
        res_valid = 1'b0;
        res_err   = 1'b0;
        res_off   = r_pos;
        fc_go     = 1'b0;
        td_go     = 1'b0;

        if (r_phase != aip_pkg::PH_DRAIN && r_base_code > aip_pkg::BC_HEX) begin
            res_valid = 1'b1;
            res_err   = 1'b1;
        end else begin
            case (r_phase)
                aip_pkg::PH_WS: begin
                    if (is_ws) begin
                        if (r_in_last) begin
                            res_valid = 1'b1;
                            res_err   = 1'b1;
                            res_off   = pos_inc;
                        end
                    end else if (is_sign) begin
                        n_neg   = (r_in_ch == aip_pkg::CH_MINUS);
                        n_phase = aip_pkg::PH_SIGNED;
                        if (r_in_last) begin
                            res_valid = 1'b1;
                            res_err   = 1'b1;
                            res_off   = pos_inc;
                        end
                    end else begin
                        fc_go = 1'b1;
                    end
                end
                aip_pkg::PH_SIGNED: fc_go = 1'b1;
                aip_pkg::PH_AUTO0, aip_pkg::PH_HEX0: begin
                    if (is_x) begin
                        n_base  = aip_pkg::AB_16;
                        n_phase = aip_pkg::PH_DIGITS;
                        if (r_in_last) begin
                            res_valid = 1'b1;
                            res_err   = 1'b1;
                            res_off   = pos_inc;
                        end
                    end else begin
                        td_go = 1'b1;
                    end
                end
                aip_pkg::PH_DIGITS: td_go = 1'b1;
                default: ;
            endcase
        end

        if (fc_go) begin
            if (r_base_code == aip_pkg::BC_AUTO) begin
                if (!is_zero) begin
                    n_base = aip_pkg::AB_10;
                    td_go  = 1'b1;
                end else begin
                    n_base = aip_pkg::AB_8;
                    if (r_in_last) begin
                        res_valid = 1'b1;
                        res_off   = pos_inc;
                    end else begin
                        n_phase = aip_pkg::PH_AUTO0;
                    end
                end
            end else begin
                n_base = code_base;
                if (is_zero && r_base_code == aip_pkg::BC_OCT) begin
                    if (r_in_last) begin
                        res_valid = 1'b1;
                        res_off   = pos_inc;
                    end else begin
                        n_phase = aip_pkg::PH_DIGITS;
                    end
                end else if (is_zero && r_base_code == aip_pkg::BC_HEX && !r_in_last) begin
                    n_phase = aip_pkg::PH_HEX0;
                end else begin
                    td_go = 1'b1;
                end
            end
        end

        if (td_go) begin
            if (!dig[4]) begin
                res_valid = 1'b1;
            end else if (!d_ok) begin
                res_valid = 1'b1;
                res_err   = 1'b1;
            end else begin
                if (can_acc) begin
                    n_acc = acc_next;
                end else begin
                    n_ovf = 1'b1;
                end
                n_phase = aip_pkg::PH_DIGITS;
                if (r_in_last) begin
                    res_valid = 1'b1;
                    res_off   = pos_inc;
                end
            end
        end
    end

    // ---------------- saturate / negate step ----------------
    logic [63:0] p_umax, p_smag, p_val;
    logic [1:0]  p_st;
    logic        p_negate;

    assign p_umax = aip_pkg::umax_of(r_pend_wc);
    assign p_smag = (p_umax >> 1) + 64'd1;

    always_comb begin
        p_val    = r_pend_acc;
        p_st     = aip_pkg::ST_OK;
        p_negate = r_pend_neg;
        if (r_pend_ovf) begin
            p_st = aip_pkg::ST_OVF;
            if (r_pend_uns) begin
                p_val    = p_umax;
                p_negate = 1'b0;
            end else begin
                p_val = r_pend_neg ? p_smag : p_smag - 64'd1;
            end
        end else if (!r_pend_uns) begin
            if (r_pend_neg && r_pend_acc > p_smag) begin
                p_val = p_smag;
                p_st  = aip_pkg::ST_OVF;
            end else if (!r_pend_neg && r_pend_acc >= p_smag) begin
                p_val = p_smag - 64'd1;
                p_st  = aip_pkg::ST_OVF;
            end
        end
        if (p_negate) begin
            p_val = 64'd0 - p_val;
        end
        p_val = p_val & p_umax;
        if (r_pend_err) begin
            p_val = 64'd0;
            p_st  = aip_pkg::ST_FMT;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_code     <= aip_pkg::BC_DEC;
            r_want_unsigned <= 1'b0;
            r_width_code    <= aip_pkg::WC_32;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                aip_pkg::REG_BASE_CODE:     r_base_code     <= i_cfg_data;
                aip_pkg::REG_WANT_UNSIGNED: r_want_unsigned <= i_cfg_data[0];
                aip_pkg::REG_WIDTH_CODE:    r_width_code    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_ch   <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= aip_pkg::PH_WS;
            r_acc   <= 64'd0;
            r_neg   <= 1'b0;
            r_ovf   <= 1'b0;
            r_base  <= aip_pkg::AB_10;
            r_pos   <= 13'd0;
        end else if (proc_fire) begin
            if (r_in_last) begin
                r_phase <= aip_pkg::PH_WS;
                r_acc   <= 64'd0;
                r_neg   <= 1'b0;
                r_ovf   <= 1'b0;
                r_base  <= aip_pkg::AB_10;
                r_pos   <= 13'd0;
            end else begin
                r_phase <= res_valid ? aip_pkg::PH_DRAIN : n_phase;
                r_acc   <= n_acc;
                r_neg   <= n_neg;
                r_ovf   <= n_ovf;
                r_base  <= n_base;
                r_pos   <= pos_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (proc_fire && res_valid) begin
            r_pend_valid <= 1'b1;
        end else if (pend_move) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && res_valid) begin
            r_pend_err <= res_err;
            r_pend_acc <= n_acc;
            r_pend_neg <= n_neg;
            r_pend_ovf <= n_ovf;
            r_pend_uns <= r_want_unsigned;
            r_pend_wc  <= r_width_code;
            r_pend_off <= res_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pend_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_move) begin
            r_out_data <= {1'b0, r_pend_off, p_st, p_val};
        end
    end

endmodule
